[rtl/ppl_pkg.sv]
// shared types and constants of the parameter list parser
package ppl_pkg;

  localparam int VALUE_BITS = 16;

  // result queue, depth must be a power of two and at least two
  localparam int Q_DEPTH = 4;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [3:0] PARAM_LIMIT_RST = 4'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADPARAM = 2'd1;
  localparam logic [1:0] ST_NOOPEN   = 2'd2;
  localparam logic [1:0] ST_NOCLOSE  = 2'd3;

  localparam logic KIND_VALUE  = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  typedef struct packed {
    logic        kind;
    logic [3:0]  param_index;
    logic [15:0] param_value;
    logic [1:0]  status;
    logic        is_last;
  } res_t;

  // results made by one character, zero to two of them
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic valid;
    logic room;
  } q_stat_t;

endpackage

[rtl/ppl_front.sv]
// front end: takes characters, tokenizes and parses them into result items
module ppl_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [3:0]        cfg_wr_data,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,
  input  logic              in_tlast,
  input  logic              q_room,
  output ppl_pkg::push_t    push
);
  import ppl_pkg::*;

  typedef enum logic [1:0] {M_BETWEEN, M_NAME, M_NUMBER} mode_t;
  typedef enum logic [1:0] {B_DEC, B_OCT, B_HEX, B_ZERO} base_t;
  typedef enum logic [2:0] {P_OPEN, P_VAL, P_SEP, P_DOTVAL, P_SEP2, P_DONE} phase_t;
  typedef enum logic [1:0] {TK_CHAR, TK_NAME, TK_NUM, TK_EMPTY} tok_t;

  typedef struct packed {
    mode_t                 token_mode;
    base_t                 number_base;
    logic [VALUE_BITS-1:0] number_accum;
    logic                  number_stopped;
    phase_t                parse_phase;
    logic [3:0]            param_count;
    logic [VALUE_BITS-1:0] param_accum;
  } st_t;

  typedef struct packed {
    st_t        s;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } wk_t;

  function automatic st_t clear_state();
    st_t s;
    s.token_mode     = M_BETWEEN;
    s.number_base    = B_DEC;
    s.number_accum   = '0;
    s.number_stopped = 1'b0;
    s.parse_phase    = P_OPEN;
    s.param_count    = '0;
    s.param_accum    = '0;
    return s;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic [4:0] digit_val(logic [7:0] c);
    logic [4:0] d;
    d = 5'd16;
    if (is_digit(c)) d = {1'b0, c[3:0]};
    else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF))
      d = 5'(c[3:0]) + 5'd9;
    return d;
  endfunction

  function automatic st_t num_char(st_t s_in, logic [7:0] c);
    st_t        s;
    logic       go;
    logic [4:0] radix;
    logic [4:0] d;
    logic [VALUE_BITS-1:0] scaled;
    s  = s_in;
    go = !s.number_stopped;
    if (go && s.number_base == B_ZERO) begin
      if (c == CH_LX || c == CH_UX) begin
        s.number_base = B_HEX;
        go = 1'b0;
      end else begin
        s.number_base = B_OCT;
      end
    end
    radix  = (s.number_base == B_HEX) ? 5'd16 : (s.number_base == B_OCT) ? 5'd8 : 5'd10;
    scaled = (s.number_base == B_HEX) ? (s.number_accum << 4) :
             (s.number_base == B_OCT) ? (s.number_accum << 3) :
             ((s.number_accum << 3) + (s.number_accum << 1));
    d = digit_val(c);
    if (go) begin
      if (d >= radix) s.number_stopped = 1'b1;
      else s.number_accum = scaled + VALUE_BITS'(d);
    end
    return s;
  endfunction

  function automatic st_t num_start(st_t s_in, logic [7:0] c);
    st_t s;
    s = s_in;
    s.number_stopped = 1'b0;
    if (c == CH_0) begin
      s.number_base  = B_ZERO;
      s.number_accum = '0;
    end else begin
      s.number_base  = B_DEC;
      s.number_accum = VALUE_BITS'(c[3:0]);
    end
    return s;
  endfunction

  // results beyond the second are dropped
  function automatic wk_t emit(wk_t w_in, res_t r);
    wk_t w;
    w = w_in;
    if (w.n == 2'd0) begin
      w.r0 = r;
      w.n  = 2'd1;
    end else if (w.n == 2'd1) begin
      w.r1 = r;
      w.n  = 2'd2;
    end
    return w;
  endfunction

  function automatic wk_t finish(wk_t w_in, logic [1:0] st);
    wk_t  w;
    res_t r;
    r.kind        = KIND_STATUS;
    r.param_index = '0;
    r.param_value = '0;
    r.status      = st;
    r.is_last     = 1'b1;
    w = emit(w_in, r);
    w.s.parse_phase = P_DONE;
    return w;
  endfunction

  function automatic wk_t emit_value(wk_t w_in);
    res_t r;
    r.kind        = KIND_VALUE;
    r.param_index = w_in.s.param_count;
    r.param_value = 16'(w_in.s.param_accum);
    r.status      = ST_OK;
    r.is_last     = 1'b0;
    return emit(w_in, r);
  endfunction

  function automatic wk_t sep_seen(wk_t w_in, tok_t k, logic [7:0] code, logic at_end,
                                   logic [3:0] limit);
    wk_t        w;
    logic [1:0] st;
    w  = w_in;
    st = (k == TK_CHAR && code == CH_RPAR) ? ST_OK : ST_NOCLOSE;
    if (at_end) begin
      w = finish(w, st);
    end else begin
      w.s.param_count = w.s.param_count + 4'd1;
      if (w.s.param_count >= limit) w = finish(w, st);
      else w.s.parse_phase = P_VAL;
    end
    return w;
  endfunction

  function automatic wk_t deliver(wk_t w_in, tok_t k, logic [7:0] code, logic at_end,
                                  logic [3:0] limit);
    wk_t w;
    w = w_in;
    unique case (w.s.parse_phase)
      P_OPEN: begin
        if (k == TK_CHAR && code == CH_LPAR) begin
          if (limit == 4'd0) begin
            w = finish(w, ST_NOCLOSE);
          end else begin
            w.s.param_count = '0;
            w.s.parse_phase = P_VAL;
          end
        end else begin
          w = finish(w, ST_NOOPEN);
        end
      end
      P_VAL: begin
        if (k == TK_NUM) begin
          w.s.param_accum = w.s.number_accum;
          w.s.parse_phase = P_SEP;
        end else begin
          w = finish(w, ST_BADPARAM);
        end
      end
      P_SEP: begin
        if (k == TK_CHAR && code == CH_DOT) begin
          w.s.parse_phase = P_DOTVAL;
        end else begin
          w = emit_value(w);
          w = sep_seen(w, k, code, at_end, limit);
        end
      end
      P_DOTVAL: begin
        if (k == TK_NUM) begin
          w.s.param_accum = (w.s.param_accum << 8) + w.s.number_accum;
          w = emit_value(w);
          w.s.parse_phase = P_SEP2;
        end else begin
          w = finish(w, ST_BADPARAM);
        end
      end
      P_SEP2: begin
        w = sep_seen(w, k, code, at_end, limit);
      end
      default: begin
      end
    endcase
    return w;
  endfunction

  st_t        st_r, st_nxt;
  logic [3:0] limit_r;
  logic       acc;
  wk_t        w;

  assign in_tready = q_room;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    w    = '0;
    w.s  = st_r;
    // a pending name or number ends at any character that is not alphanumeric
    if (w.s.token_mode != M_BETWEEN) begin
      if (is_alpha(in_tdata) || is_digit(in_tdata)) begin
        if (w.s.token_mode == M_NUMBER) w.s = num_char(w.s, in_tdata);
      end else begin
        w = deliver(w, (w.s.token_mode == M_NAME) ? TK_NAME : TK_NUM, '0, 1'b0, limit_r);
        w.s.token_mode = M_BETWEEN;
      end
    end
    if (w.s.token_mode == M_BETWEEN && in_tdata != CH_SPACE) begin
      if (is_alpha(in_tdata)) begin
        w.s.token_mode = M_NAME;
      end else if (is_digit(in_tdata)) begin
        w.s.token_mode = M_NUMBER;
        w.s = num_start(w.s, in_tdata);
      end else begin
        w = deliver(w, TK_CHAR, in_tdata, in_tlast, limit_r);
      end
    end
    if (in_tlast) begin
      if (w.s.token_mode != M_BETWEEN)
        w = deliver(w, (w.s.token_mode == M_NAME) ? TK_NAME : TK_NUM, '0, 1'b1, limit_r);
      w = deliver(w, TK_EMPTY, '0, 1'b1, limit_r);
      w.s = clear_state();
    end
    st_nxt = w.s;
    push.n  = acc ? w.n : 2'd0;
    push.r0 = w.r0;
    push.r1 = w.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= clear_state();
      limit_r <= PARAM_LIMIT_RST;
    end else begin
      if (cfg_wr_en) limit_r <= cfg_wr_data;
      if (acc) st_r <= st_nxt;
    end
  end

endmodule

[rtl/ppl_queue.sv]
// result queue: up to two items in per cycle, one out, head drives the output
module ppl_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  ppl_pkg::push_t     push,
  input  logic               pop_ready,
  output ppl_pkg::res_t      head,
  output ppl_pkg::q_stat_t   stat
);
  import ppl_pkg::*;

  res_t              mem_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr1;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              pop;

  assign stat.valid = (cnt_r != '0);
  assign stat.room  = (cnt_r <= QCNT_W'(Q_DEPTH - 2));
  assign head       = mem_r[rd_ptr_r];
  assign pop        = stat.valid && pop_ready;
  assign wr_ptr1    = wr_ptr_r + QPTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.n);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
    cnt_nxt    = cnt_r + QCNT_W'(push.n) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_ptr_r] <= push.r0;
    if (push.n == 2'd2) mem_r[wr_ptr1] <= push.r1;
  end

endmodule

[rtl/paren_param_list_parser_top.sv]
// Parser for parenthesized numeric parameter lists, one character per item.
// Input channel: one character per item in in_tdata, in_tlast set on the last
// character of a command text. Output channel: parameter values (out_tuser 0)
// and one closing status per text (out_tuser 1, out_tlast 1).
// cfg_wr_en/cfg_wr_data set the most parameters taken in one list; write it
// only while the block is idle.
// Throughput: one character per cycle while the queue has room. A result is
// registered into the queue when its character is accepted. A character makes
// at most two results; they go into a four-entry queue whose head drives the
// output. in_tready drops while fewer than two queue entries are free, so a
// stalled receiver holds off the sender once three or four results are
// pending; nothing is lost. Sustained rate is set by the output side at one
// result a cycle.
// Reset: list limit goes to 4, the parser waits for an opening paren and the
// queue is emptied.
module paren_param_list_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,   // param_limit
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // char_code
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,     // param_index[3:0], param_value[19:4], status[21:20], zero
  output logic        out_tuser,     // kind
  output logic        out_tlast
);
  import ppl_pkg::*;

  push_t   push;
  res_t    head;
  q_stat_t q_stat;

  ppl_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .q_room     (q_stat.room),
    .push       (push)
  );

  ppl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop_ready(out_tready),
    .head     (head),
    .stat     (q_stat)
  );

  assign out_tvalid = q_stat.valid;
  assign out_tdata  = {2'b00, head.status, head.param_value, head.param_index};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.is_last;

`ifndef SYNTH
  // a status item always closes the text, a value never does
  a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == out_tlast))
    else $error("status/last mismatch");

  // values carry status ok
  a_value_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[21:20] == ST_OK))
    else $error("value item with nonzero status");

  // results enter the queue only on an accepted item
  a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> (in_tvalid && in_tready))
    else $error("queue push without accepted item");

  // an empty queue always has room
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty queue");
`endif

endmodule
